// File: rtl/tlik_pkg.sv
// ---------------------------------------------------------------------------
// tlik_pkg: shared types, constants and arithmetic steps
// Types and step functions for the two-link leg inverse kinematics block.
// ---------------------------------------------------------------------------
package tlik_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_UPPER_LEN = 3'd0;
    localparam logic [2:0] REG_LOWER_LEN = 3'd1;
    localparam logic [2:0] REG_Y_LO      = 3'd2;
    localparam logic [2:0] REG_Y_HI      = 3'd3;
    localparam logic [2:0] REG_Z_LO      = 3'd4;
    localparam logic [2:0] REG_Z_HI      = 3'd5;

    localparam int CORDIC_ITERS = 16;
    localparam int SQRT_STEPS   = 25;   // root bits of a 50-bit radicand

    typedef logic signed [14:0] coord_t;
    typedef logic signed [53:0] cw_t;   // CORDIC x/y, operands scaled by 2^24
    typedef logic signed [27:0] ca_t;   // CORDIC angle, Q16 degrees

    localparam ca_t DEG90  = ca_t'(90 * 65536);
    localparam ca_t DEG180 = ca_t'(180 * 65536);

    // clamped foot target, front to back
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // side data that rides along the back pipeline
    typedef struct packed {
        coord_t             x;
        coord_t             y;
        logic signed [25:0] n;        // law-of-cosines numerator, valid when in reach
        logic               oor;
        logic [7:0]         knee_fix; // knee when out of reach
    } carry_t;

    typedef struct packed {
        logic [49:0] rem;
        logic [50:0] res;
    } sq_t;

    typedef struct packed {
        cw_t x;
        cw_t y;
        ca_t z;
    } cs_t;

    function automatic ca_t atan_entry(input int unsigned i);
        ca_t r;
        case (i)
            0:       r = ca_t'(2949120);
            1:       r = ca_t'(1740967);
            2:       r = ca_t'(919879);
            3:       r = ca_t'(466945);
            4:       r = ca_t'(234379);
            5:       r = ca_t'(117304);
            6:       r = ca_t'(58666);
            7:       r = ca_t'(29335);
            8:       r = ca_t'(14668);
            9:       r = ca_t'(7334);
            10:      r = ca_t'(3667);
            11:      r = ca_t'(1833);
            12:      r = ca_t'(917);
            13:      r = ca_t'(458);
            14:      r = ca_t'(229);
            15:      r = ca_t'(115);
            default: r = '0;
        endcase
        return r;
    endfunction

    // one digit of the bitwise square root; sh is twice the digit position
    function automatic sq_t isqrt_step(input sq_t a, input int unsigned sh);
        logic [50:0] b;
        logic [50:0] t;
        sq_t         r;
        b = 51'(1) << sh;
        t = a.res + b;
        if ({1'b0, a.rem} >= t)
        begin
            r.rem = 50'({1'b0, a.rem} - t);
            r.res = (a.res >> 1) + b;
        end
        else
        begin
            r.rem = a.rem;
            r.res = a.res >> 1;
        end
        return r;
    endfunction

    // quadrant handling and scaling ahead of the vectoring loop
    function automatic cs_t cordic_prep(input logic signed [31:0] y,
                                        input logic signed [31:0] x);
        cs_t r;
        cw_t xs;
        cw_t ys;
        xs = cw_t'(x);
        ys = cw_t'(y);
        r.z = '0;
        if (x == 0)
        begin
            if (y > 0)
                r.z = DEG90;
            else if (y < 0)
                r.z = -DEG90;
            xs = '0;
            ys = '0;
        end
        else if (y == 0)
        begin
            if (x < 0)
                r.z = DEG180;
        end
        else if (x < 0)
        begin
            r.z = (y > 0) ? DEG180 : -DEG180;
            xs = -xs;
            ys = -ys;
        end
        r.x = xs <<< 24;
        r.y = ys <<< 24;
        return r;
    endfunction

    function automatic cs_t cordic_iter(input cs_t a, input int unsigned i);
        cs_t r;
        r = a;
        if (a.y > 0)
        begin
            r.x = a.x + (a.y >>> i);
            r.y = a.y - (a.x >>> i);
            r.z = a.z + atan_entry(i);
        end
        else if (a.y < 0)
        begin
            r.x = a.x - (a.y >>> i);
            r.y = a.y + (a.x >>> i);
            r.z = a.z - atan_entry(i);
        end
        return r;
    endfunction

    // Q16 degrees to whole degrees, toward zero
    function automatic logic signed [11:0] trunc_deg(input ca_t q);
        ca_t m;
        m = (q < 0) ? -q : q;
        m = m >>> 16;
        return (q < 0) ? -12'(m) : 12'(m);
    endfunction

endpackage

// File: rtl/tlik_front.sv
// ---------------------------------------------------------------------------
// tlik_front: target intake and clamp
// Takes foot targets and snaps (y, z) to the upper or lower limit pair when y or z reaches it.
// ---------------------------------------------------------------------------
module tlik_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tlik_pkg::coord_t  target_x,
    input  tlik_pkg::coord_t  target_y,
    input  tlik_pkg::coord_t  target_z,
    input  tlik_pkg::coord_t  y_lo,
    input  tlik_pkg::coord_t  y_hi,
    input  tlik_pkg::coord_t  z_lo,
    input  tlik_pkg::coord_t  z_hi,
    output logic              push_valid,
    input  logic              push_ready,
    output tlik_pkg::point_t  push_data
);

    logic             valid_reg;
    logic             valid_next;
    tlik_pkg::point_t pt_reg;
    tlik_pkg::point_t pt_next;
    logic             take;

    assign in_ready   = !valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_data  = pt_reg;

    always_comb
    begin
        valid_next = take || (valid_reg && !push_ready);
        pt_next.x  = target_x;
        // upper pair wins over lower pair
        if (target_z >= z_hi || target_y >= y_hi)
        begin
            pt_next.y = y_hi;
            pt_next.z = z_hi;
        end
        else if (target_z <= z_lo || target_y <= y_lo)
        begin
            pt_next.y = y_lo;
            pt_next.z = z_lo;
        end
        else
        begin
            pt_next.y = target_y;
            pt_next.z = target_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            pt_reg <= pt_next;
    end

endmodule

// File: rtl/tlik_fifo.sv
// ---------------------------------------------------------------------------
// tlik_fifo: short queue between front and back
// Four-entry first-in first-out queue of clamped targets.
// ---------------------------------------------------------------------------
module tlik_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  tlik_pkg::point_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output tlik_pkg::point_t  pop_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    tlik_pkg::point_t entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/tlik_back.sv
// ---------------------------------------------------------------------------
// tlik_back: angle pipeline
// Law-of-cosines terms, pipelined square root and two CORDIC vectoring
// pipelines; the last stage is the output register.
// ---------------------------------------------------------------------------
module tlik_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [11:0]       l1,
    input  logic [11:0]       l2,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  tlik_pkg::point_t  pop_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [8:0] hip_angle,
    output logic [7:0]        knee_angle,
    output logic              out_of_reach
);

    localparam int NQ = tlik_pkg::SQRT_STEPS;
    localparam int NC = tlik_pkg::CORDIC_ITERS;

    logic adv;
    logic take;

    // whole pipeline moves when the output register is free or drained
    assign adv       = !out_valid || out_ready;
    assign pop_ready = adv;
    assign take      = adv && pop_valid;

    // stage 1: squares and product
    logic                  s1_v_reg;
    tlik_pkg::carry_t      s1_c_reg;
    logic signed [29:0]    s1_ysq_reg;
    logic signed [29:0]    s1_zsq_reg;
    logic [23:0]           s1_l1sq_reg;
    logic [23:0]           s1_l2sq_reg;
    logic [23:0]           s1_l12_reg;
    // stage 2: numerator and denominator
    logic                  s2_v_reg;
    tlik_pkg::carry_t      s2_c_reg;
    logic signed [31:0]    s2_n_reg;
    logic [24:0]           s2_d_reg;
    // stage 3: reach check, D^2 and N^2
    logic                  s3_v_reg;
    tlik_pkg::carry_t      s3_c_reg;
    logic [49:0]           s3_d2_reg;
    logic [49:0]           s3_n2_reg;
    // stage 4: radicand
    logic                  s4_v_reg;
    tlik_pkg::carry_t      s4_c_reg;
    logic [49:0]           s4_rad_reg;

    logic signed [31:0]    n_s2;
    logic signed [31:0]    d_s3;
    logic signed [31:0]    absn_s3;
    tlik_pkg::carry_t      c_s3;

    always_comb
    begin
        n_s2 = $signed({8'd0, s1_l1sq_reg}) + $signed({8'd0, s1_l2sq_reg})
             - 32'(s1_ysq_reg) - 32'(s1_zsq_reg);
        d_s3    = $signed({7'd0, s2_d_reg});
        absn_s3 = (s2_n_reg < 0) ? -s2_n_reg : s2_n_reg;
        c_s3    = s2_c_reg;
        c_s3.n  = s2_n_reg[25:0];
        if (s2_d_reg == '0)
        begin
            c_s3.oor      = 1'b1;
            c_s3.knee_fix = (s2_n_reg < 0) ? 8'd180 : 8'd0;
        end
        else if (s2_n_reg > d_s3)
        begin
            c_s3.oor      = 1'b1;
            c_s3.knee_fix = 8'd0;
        end
        else if (s2_n_reg < -d_s3)
        begin
            c_s3.oor      = 1'b1;
            c_s3.knee_fix = 8'd180;
        end
        else
        begin
            c_s3.oor      = 1'b0;
            c_s3.knee_fix = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= take;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_c_reg.x        <= pop_data.x;
            s1_c_reg.y        <= pop_data.y;
            s1_c_reg.n        <= '0;
            s1_c_reg.oor      <= 1'b0;
            s1_c_reg.knee_fix <= '0;
            s1_ysq_reg        <= pop_data.y * pop_data.y;
            s1_zsq_reg        <= pop_data.z * pop_data.z;
            s1_l1sq_reg       <= l1 * l1;
            s1_l2sq_reg       <= l2 * l2;
            s1_l12_reg        <= l1 * l2;

            s2_c_reg          <= s1_c_reg;
            s2_n_reg          <= n_s2;
            s2_d_reg          <= {s1_l12_reg, 1'b0};

            s3_c_reg          <= c_s3;
            s3_d2_reg         <= s2_d_reg * s2_d_reg;
            s3_n2_reg         <= absn_s3[24:0] * absn_s3[24:0];

            s4_c_reg          <= s3_c_reg;
            s4_rad_reg        <= s3_d2_reg - s3_n2_reg;
        end
    end

    // square root, one root bit per stage
    logic             q_v_reg [NQ];
    tlik_pkg::carry_t q_c_reg [NQ];
    tlik_pkg::sq_t    q_s_reg [NQ];

    for (genvar k = 0; k < NQ; k++)
    begin : g_sqrt
        logic             v_in;
        tlik_pkg::carry_t c_in;
        tlik_pkg::sq_t    s_in;
        if (k == 0)
        begin : g_first
            assign v_in      = s4_v_reg;
            assign c_in      = s4_c_reg;
            assign s_in.rem  = s4_rad_reg;
            assign s_in.res  = '0;
        end
        else
        begin : g_next
            assign v_in = q_v_reg[k-1];
            assign c_in = q_c_reg[k-1];
            assign s_in = q_s_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                q_v_reg[k] <= 1'b0;
            else if (adv)
                q_v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_c_reg[k] <= c_in;
                q_s_reg[k] <= tlik_pkg::isqrt_step(s_in, 2 * (NQ - 1 - k));
            end
        end
    end

    // CORDIC set-up for both angles
    logic             p_v_reg;
    tlik_pkg::carry_t p_c_reg;
    tlik_pkg::cs_t    p_h_reg;
    tlik_pkg::cs_t    p_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_v_reg <= 1'b0;
        else if (adv)
            p_v_reg <= q_v_reg[NQ-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_c_reg <= q_c_reg[NQ-1];
            p_h_reg <= tlik_pkg::cordic_prep(32'(q_c_reg[NQ-1].y), 32'(q_c_reg[NQ-1].x));
            p_k_reg <= tlik_pkg::cordic_prep($signed({7'd0, q_s_reg[NQ-1].res[24:0]}),
                                             32'(q_c_reg[NQ-1].n));
        end
    end

    // vectoring iterations, hip and knee side by side
    logic             c_v_reg [NC];
    tlik_pkg::carry_t c_c_reg [NC];
    tlik_pkg::cs_t    c_h_reg [NC];
    tlik_pkg::cs_t    c_k_reg [NC];

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        logic             v_in;
        tlik_pkg::carry_t c_in;
        tlik_pkg::cs_t    h_in;
        tlik_pkg::cs_t    k_in;
        if (i == 0)
        begin : g_first
            assign v_in = p_v_reg;
            assign c_in = p_c_reg;
            assign h_in = p_h_reg;
            assign k_in = p_k_reg;
        end
        else
        begin : g_next
            assign v_in = c_v_reg[i-1];
            assign c_in = c_c_reg[i-1];
            assign h_in = c_h_reg[i-1];
            assign k_in = c_k_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c_v_reg[i] <= 1'b0;
            else if (adv)
                c_v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_c_reg[i] <= c_in;
                c_h_reg[i] <= tlik_pkg::cordic_iter(h_in, i);
                c_k_reg[i] <= tlik_pkg::cordic_iter(k_in, i);
            end
        end
    end

    // output register
    logic               o_v_reg;
    logic signed [8:0]  o_hip_reg;
    logic [7:0]         o_knee_reg;
    logic               o_oor_reg;
    logic signed [11:0] hip_deg;
    logic signed [11:0] knee_deg;
    logic signed [8:0]  hip_sat;
    logic [7:0]         knee_sat;

    always_comb
    begin
        hip_deg  = tlik_pkg::trunc_deg(c_h_reg[NC-1].z);
        knee_deg = tlik_pkg::trunc_deg(c_k_reg[NC-1].z);
        if (hip_deg > 12'sd180)
            hip_sat = 9'sd180;
        else if (hip_deg < -12'sd180)
            hip_sat = -9'sd180;
        else
            hip_sat = hip_deg[8:0];
        if (c_c_reg[NC-1].oor)
            knee_sat = c_c_reg[NC-1].knee_fix;
        else if (knee_deg < 0)
            knee_sat = 8'd0;
        else if (knee_deg > 12'sd180)
            knee_sat = 8'd180;
        else
            knee_sat = knee_deg[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (adv)
            o_v_reg <= c_v_reg[NC-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_hip_reg  <= hip_sat;
            o_knee_reg <= knee_sat;
            o_oor_reg  <= c_c_reg[NC-1].oor;
        end
    end

    assign out_valid    = o_v_reg;
    assign hip_angle    = o_hip_reg;
    assign knee_angle   = o_knee_reg;
    assign out_of_reach = o_oor_reg;

endmodule

// File: rtl/two_link_leg_inverse_kinematics_top.sv
// ---------------------------------------------------------------------------
// two_link_leg_inverse_kinematics_top: leg joint angles from a foot target
// Hip angle atan2(y, x) and knee angle by the law of cosines, whole degrees.
// ---------------------------------------------------------------------------
// Usage
//   Input channel: in_valid/in_ready, one beat is one foot target
//   (target_x, target_y, target_z), signed, 1/16 mm at the default FRAC_BITS.
//   Output channel: out_valid/out_ready, one beat per target with
//   hip_angle, knee_angle and out_of_reach, in the order taken.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 upper link, 1 lower link, 2/3 y low/high, 4/5 z low/high); write
//   only while no beat is in flight. Indexes 6 and 7 are ignored.
//   Throughput: one target per cycle when not stalled. A beat passes the
//   front register, queue, four term stages, 25-stage square root,
//   CORDIC set-up register, 16-stage CORDIC and output register.
//   Stalls: when out_valid is high and out_ready low the back pipeline
//   holds; the front keeps filling the four-entry queue, so in_ready drops
//   only once the queue and the front register are full.
//   Reset: pipeline and queue empty, registers at their defaults (50 mm
//   links, y 40..78 mm, z -76..-60 mm at the configured fraction bits).
// ---------------------------------------------------------------------------
module two_link_leg_inverse_kinematics_top #(
    parameter int FRAC_BITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic signed [14:0] target_x,
    input  logic signed [14:0] target_y,
    input  logic signed [14:0] target_z,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [8:0] hip_angle,
    output logic [7:0]        knee_angle,
    output logic              out_of_reach,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [14:0]       cfg_wdata
);

    localparam int ONE = 1 << FRAC_BITS;
    // defaults wrap to the register widths
    localparam logic [11:0]      RST_LEN  = 12'(50 * ONE);
    localparam tlik_pkg::coord_t RST_Y_LO = 15'(40 * ONE);
    localparam tlik_pkg::coord_t RST_Y_HI = 15'(78 * ONE);
    localparam tlik_pkg::coord_t RST_Z_LO = 15'(-76 * ONE);
    localparam tlik_pkg::coord_t RST_Z_HI = 15'(-60 * ONE);

    logic [11:0]      l1_reg;
    logic [11:0]      l2_reg;
    tlik_pkg::coord_t y_lo_reg;
    tlik_pkg::coord_t y_hi_reg;
    tlik_pkg::coord_t z_lo_reg;
    tlik_pkg::coord_t z_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg   <= RST_LEN;
            l2_reg   <= RST_LEN;
            y_lo_reg <= RST_Y_LO;
            y_hi_reg <= RST_Y_HI;
            z_lo_reg <= RST_Z_LO;
            z_hi_reg <= RST_Z_HI;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tlik_pkg::REG_UPPER_LEN: l1_reg   <= cfg_wdata[11:0];
                tlik_pkg::REG_LOWER_LEN: l2_reg   <= cfg_wdata[11:0];
                tlik_pkg::REG_Y_LO:      y_lo_reg <= cfg_wdata;
                tlik_pkg::REG_Y_HI:      y_hi_reg <= cfg_wdata;
                tlik_pkg::REG_Z_LO:      z_lo_reg <= cfg_wdata;
                tlik_pkg::REG_Z_HI:      z_hi_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic             push_valid;
    logic             push_ready;
    tlik_pkg::point_t push_data;
    logic             pop_valid;
    logic             pop_ready;
    tlik_pkg::point_t pop_data;

    // front: intake register and (y, z) clamp
    tlik_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .target_x   (target_x),
        .target_y   (target_y),
        .target_z   (target_z),
        .y_lo       (y_lo_reg),
        .y_hi       (y_hi_reg),
        .z_lo       (z_lo_reg),
        .z_hi       (z_hi_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // queue decouples front from a stalled back
    tlik_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: cosine terms, square root, CORDIC, output register
    tlik_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .l1           (l1_reg),
        .l2           (l2_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hip_angle    (hip_angle),
        .knee_angle   (knee_angle),
        .out_of_reach (out_of_reach)
    );

endmodule

// File: rtl/tlik_checker.sv
// ---------------------------------------------------------------------------
// tlik_checker: port-level checks
// Output channel behaviour and angle ranges seen on the top-level ports.
// ---------------------------------------------------------------------------
module tlik_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [8:0] hip_angle,
    input logic [7:0]        knee_angle,
    input logic              out_of_reach
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(hip_angle) && $stable(knee_angle) && $stable(out_of_reach))
        else $error("output beat changed while stalled");

    a_hip_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hip_angle <= 9'sd180) && (hip_angle >= -9'sd180))
        else $error("hip angle out of range");

    a_knee_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> knee_angle <= 8'd180)
        else $error("knee angle out of range");

endmodule

bind two_link_leg_inverse_kinematics_top tlik_checker u_tlik_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hip_angle    (hip_angle),
    .knee_angle   (knee_angle),
    .out_of_reach (out_of_reach)
);
